// File: rtl/core/linear_adsr_envelope_level_core_macros.svh
// Assertion macros shared by the envelope core modules.
// Each macro expects clk and rst_n in scope.
`ifndef LINEAR_ADSR_ENVELOPE_LEVEL_CORE_MACROS_SVH
`define LINEAR_ADSR_ENVELOPE_LEVEL_CORE_MACROS_SVH

`define LAE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define LAE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define LAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/laenv_pkg.sv
package laenv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 17;
  localparam int TIME_W    = 19;
  localparam int PROD_W    = 2 * REG_W;
  localparam int ADDR_W    = 3;

  localparam logic [REG_W-1:0] ONE = REG_W'(1) << FRAC_BITS;

  localparam logic [ADDR_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [ADDR_W-1:0] REG_HOLD    = 3'd3;
  localparam logic [ADDR_W-1:0] REG_RELEASE = 3'd4;

  localparam logic [2:0] SEG_ATTACK  = 3'd0;
  localparam logic [2:0] SEG_DECAY   = 3'd1;
  localparam logic [2:0] SEG_HOLD    = 3'd2;
  localparam logic [2:0] SEG_RELEASE = 3'd3;
  localparam logic [2:0] SEG_DONE    = 3'd4;

  typedef struct packed {
    logic [REG_W-1:0] atk;
    logic [REG_W-1:0] dec;
    logic [REG_W-1:0] sus;
    logic [REG_W-1:0] hld;
    logic [REG_W-1:0] rls;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0]           seg;
    logic [REG_W-1:0]     rem;
    logic [REG_W-1:0]     len;
    logic [FRAC_BITS-1:0] q;
  } div_word_t;

endpackage

// File: rtl/core/laenv_front.sv
module laenv_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  laenv_pkg::cfg_regs_t        cfg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [laenv_pkg::TIME_W-1:0] up_time,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output laenv_pkg::div_word_t        dn_word
);

  logic [laenv_pkg::TIME_W-1:0] b1, b2, b3, b4, diff;
  laenv_pkg::div_word_t         word_nxt, word_r;
  logic                         valid_r, valid_nxt;

  always_comb begin
    b1 = {{(laenv_pkg::TIME_W - laenv_pkg::REG_W){1'b0}}, cfg.atk};
    b2 = b1 + laenv_pkg::TIME_W'(cfg.dec);
    b3 = b2 + laenv_pkg::TIME_W'(cfg.hld);
    b4 = b3 + laenv_pkg::TIME_W'(cfg.rls);
    diff = '0;
    word_nxt.q = '0;
    if (up_time < b1) begin
      word_nxt.seg = laenv_pkg::SEG_ATTACK;
      word_nxt.rem = up_time[laenv_pkg::REG_W-1:0];
      word_nxt.len = cfg.atk;
    end else if (up_time < b2) begin
      diff = up_time - b1;
      word_nxt.seg = laenv_pkg::SEG_DECAY;
      word_nxt.rem = diff[laenv_pkg::REG_W-1:0];
      word_nxt.len = cfg.dec;
    end else if (up_time < b3) begin
      word_nxt.seg = laenv_pkg::SEG_HOLD;
      word_nxt.rem = '0;
      word_nxt.len = laenv_pkg::ONE;
    end else if (up_time < b4) begin
      diff = up_time - b3;
      word_nxt.seg = laenv_pkg::SEG_RELEASE;
      word_nxt.rem = diff[laenv_pkg::REG_W-1:0];
      word_nxt.len = cfg.rls;
    end else begin
      word_nxt.seg = laenv_pkg::SEG_DONE;
      word_nxt.rem = '0;
      word_nxt.len = laenv_pkg::ONE;
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// File: rtl/core/laenv_cell.sv
`include "linear_adsr_envelope_level_core_macros.svh"

module laenv_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  laenv_pkg::div_word_t up_word,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output laenv_pkg::div_word_t dn_word
);

  logic [laenv_pkg::REG_W:0] dbl, trial;
  logic                      ge;
  laenv_pkg::div_word_t      word_nxt, word_r;
  logic                      valid_r, valid_nxt;

  // One restoring division step: one quotient bit per cell.
  always_comb begin
    dbl      = {up_word.rem, 1'b0};
    trial    = dbl - {1'b0, up_word.len};
    ge       = dbl >= {1'b0, up_word.len};
    word_nxt = up_word;
    word_nxt.rem = ge ? trial[laenv_pkg::REG_W-1:0] : dbl[laenv_pkg::REG_W-1:0];
    word_nxt.q   = {up_word.q[laenv_pkg::FRAC_BITS-2:0], ge};
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  `LAE_ASSERT_IMPLIES(a_rem_below_len, valid_r, word_r.rem < word_r.len, "remainder reached divisor")
  `LAE_ASSERT_NEXT(a_stall_holds, valid_r && !dn_ready, valid_r && word_r == $past(word_r), "stalled item changed")

endmodule

// File: rtl/core/laenv_back.sv
module laenv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [laenv_pkg::REG_W-1:0] sus,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  laenv_pkg::div_word_t        up_word,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [laenv_pkg::REG_W-1:0] dn_level
);

  logic [laenv_pkg::REG_W-1:0]     op_a, op_b, q_ext, scaled;
  logic [laenv_pkg::PROD_W-1:0]    prod_r;
  logic [2:0]                      seg_r;
  logic [laenv_pkg::FRAC_BITS-1:0] q_r;
  logic                            vm_r, vm_nxt, m_ready;
  logic [laenv_pkg::REG_W-1:0]     level_nxt, level_r;
  logic                            vo_r, vo_nxt, o_ready;

  assign q_ext = {{(laenv_pkg::REG_W - laenv_pkg::FRAC_BITS){1'b0}}, up_word.q};

  always_comb begin
    case (up_word.seg)
      laenv_pkg::SEG_DECAY: begin
        op_a = laenv_pkg::ONE - sus;
        op_b = q_ext;
      end
      laenv_pkg::SEG_RELEASE: begin
        op_a = sus;
        op_b = laenv_pkg::ONE - q_ext;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign o_ready = !vo_r || dn_ready;
  assign m_ready = !vm_r || o_ready;
  assign up_ready = m_ready;
  assign vm_nxt  = m_ready ? up_valid : vm_r;
  assign vo_nxt  = o_ready ? vm_r : vo_r;

  assign scaled = prod_r[laenv_pkg::FRAC_BITS +: laenv_pkg::REG_W];

  always_comb begin
    case (seg_r)
      laenv_pkg::SEG_ATTACK:  level_nxt = {{(laenv_pkg::REG_W - laenv_pkg::FRAC_BITS){1'b0}}, q_r};
      laenv_pkg::SEG_DECAY:   level_nxt = laenv_pkg::ONE - scaled;
      laenv_pkg::SEG_HOLD:    level_nxt = sus;
      laenv_pkg::SEG_RELEASE: level_nxt = scaled;
      default:                level_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vm_r <= vm_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && m_ready) begin
      prod_r <= op_a * op_b;
      seg_r  <= up_word.seg;
      q_r    <= up_word.q;
    end
    if (vm_r && o_ready) begin
      level_r <= level_nxt;
    end
  end

  assign dn_valid = vo_r;
  assign dn_level = level_r;

endmodule

// File: rtl/core/linear_adsr_envelope_level_core.sv
// Evaluates a linear attack/decay/hold/release envelope at one elapsed time
// per item, with 16 fraction bits (65536 is 1.0); the core keeps no state
// between items. Register values above 1.0 are clamped to 1.0 when written,
// and a segment of zero length is skipped. A new item can enter every clock
// cycle while the output is not stalled; each item passes the segment selection
// register, a row of 16 divider cells that produce one quotient bit each, the
// scaling multiply register and the output register. Every stage holds its
// item under backpressure and the input keeps accepting while bubbles remain.
// The user must write registers only while no item is in flight; the core
// itself does not enforce this.
`include "linear_adsr_envelope_level_core_macros.svh"

module linear_adsr_envelope_level_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [18:0] elapsed_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [16:0] envelope_level
);

  localparam int NC = laenv_pkg::FRAC_BITS;

  laenv_pkg::cfg_regs_t        cfg_r;
  logic [laenv_pkg::REG_W-1:0] wr_val;

  laenv_pkg::div_word_t        word [0:NC];
  logic                        valid [0:NC];
  logic                        ready [0:NC];
  logic [laenv_pkg::REG_W-1:0] level;

  assign wr_val = (cfg_data > laenv_pkg::ONE) ? laenv_pkg::ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atk <= '0;
      cfg_r.dec <= '0;
      cfg_r.sus <= laenv_pkg::ONE;
      cfg_r.hld <= '0;
      cfg_r.rls <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        laenv_pkg::REG_ATTACK:  cfg_r.atk <= wr_val;
        laenv_pkg::REG_DECAY:   cfg_r.dec <= wr_val;
        laenv_pkg::REG_SUSTAIN: cfg_r.sus <= wr_val;
        laenv_pkg::REG_HOLD:    cfg_r.hld <= wr_val;
        laenv_pkg::REG_RELEASE: cfg_r.rls <= wr_val;
        default: ;
      endcase
    end
  end

  laenv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_time  (in_tdata[laenv_pkg::TIME_W-1:0]),
    .dn_valid (valid[0]),
    .dn_ready (ready[0]),
    .dn_word  (word[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    laenv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid[i]),
      .up_ready (ready[i]),
      .up_word  (word[i]),
      .dn_valid (valid[i+1]),
      .dn_ready (ready[i+1]),
      .dn_word  (word[i+1])
    );
  end

  laenv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .sus      (cfg_r.sus),
    .up_valid (valid[NC]),
    .up_ready (ready[NC]),
    .up_word  (word[NC]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_level (level)
  );

  assign out_tdata = {{(24 - laenv_pkg::REG_W){1'b0}}, level};

  `LAE_ASSERT_IMPLIES(a_level_in_range, out_tvalid, level <= laenv_pkg::ONE, "level above full scale")
  `LAE_ASSERT_IMPLIES(a_empty_out_takes, !out_tvalid, in_tready, "input blocked with empty output")

endmodule
